### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the checker modules. Each macro expects clk and
// rst_n to be visible where it is used.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds at the same edge.
`define ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// When the antecedent holds, the consequent holds at the next edge.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/wsbs_pkg.sv
// ---------------------------------------------------------------------------
// wsbs_pkg
// Widths, constants and shared types of the wake/sleep backoff scheduler.
// ---------------------------------------------------------------------------
package wsbs_pkg;

  localparam int INTERVAL_W = 27;
  localparam int SLEEP_W    = 32;
  localparam int MV_W       = 13;
  localparam int FAIL_W     = 4;
  localparam int PULSE_W    = 16;
  localparam int CFG_ADDR_W = 3;

  // Failure counter saturates here.
  localparam logic [FAIL_W-1:0] FAILURE_CAP   = 4'd8;
  localparam logic [FAIL_W-1:0] HTTP_FAIL_MIN = 4'd2;

  localparam logic [MV_W-1:0] BATT_NOREAD_MV = 13'd500;
  localparam logic [MV_W-1:0] BATT_CRIT_MV   = 13'd3100;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_REPORT_INTERVAL = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PULSE_PERIOD    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_SLEEP       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_SLEEP       = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_BATTERY_LOW     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_KEEP_ALIVE      = 3'd5;

  // Event kinds carried in the request tuser.
  localparam logic OP_WAKE        = 1'b0;
  localparam logic OP_REPORT_DONE = 1'b1;

  // Low-battery stretch, as a left shift of the interval.
  localparam logic [1:0] SCALE_X1 = 2'd0;
  localparam logic [1:0] SCALE_X2 = 2'd1;
  localparam logic [1:0] SCALE_X4 = 2'd2;

  // Start request for the backoff shifter.
  typedef struct packed {
    logic              start;
    logic [FAIL_W-1:0] shifts;
  } bo_req_t;

  // Status returned by a serial unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

### rtl/wake_sleep_backoff_scheduler.sv
// ---------------------------------------------------------------------------
// wake_sleep_backoff_scheduler
// Duty-cycle planner for a sleeping node with capped exponential backoff.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_ stream: in_tuser is the event kind (wake from
//   boot or report cycle finished), in_tdata carries the wake source, the
//   delivery status and the battery reading. Each request yields exactly one
//   result on the out_ stream: out_tuser flags a pulse-only wake, out_tdata
//   carries the sleep time, the failure count and the fallback flag.
//   The user must write configuration registers via cfg_we/cfg_addr/cfg_wdata
//   only while no request is in flight; the block itself does not enforce it.
//   A request moves from the idle state to the evaluate state and on to the
//   final step, which loads its result into the output register. A keep-alive
//   timer wake first waits in the divide state while the bit-serial divider
//   works out the interval/pulse ratio and flags it done. A failed report in
//   adaptive mode first waits in the backoff state while the backoff shifter
//   doubles the base, at most 7 doublings.
//   One request is worked on at a time; in_tready is high only when idle, so
//   a request is taken only once the previous result has left the final step.
//   A finished result waits in the output register, so a new request can be
//   accepted while the receiver stalls; it then holds in the final step.
//   Synchronous reset loads the register defaults and clears both counters.
// ---------------------------------------------------------------------------
module wake_sleep_backoff_scheduler
  import wsbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Request stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // sleep_wake, delivery_ok, battery_mv[12:0], pad
  input  logic                  in_tuser,   // op
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,  // sleep_ms[31:0], failure_count[3:0],
                                            // http_fallback_due, pad
  output logic                  out_tuser,  // pulse_only
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [SLEEP_W-1:0]    cfg_wdata
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_BACK = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  // Configuration registers.
  logic [INTERVAL_W-1:0] interval_r;
  logic [INTERVAL_W-1:0] pulse_r;
  logic [SLEEP_W-1:0]    min_r;
  logic [SLEEP_W-1:0]    max_r;
  logic [MV_W-1:0]       batt_low_r;
  logic                  keep_alive_r;

  // Persistent counters.
  logic [FAIL_W-1:0]  failures_r, failures_nxt;
  logic [PULSE_W-1:0] pcount_r, pcount_nxt;

  // Sequencer and the latched request.
  logic [2:0]     state_r, state_nxt;
  logic           op_r;
  logic           wake_r;
  logic           ok_r;
  logic [MV_W-1:0] batt_r;

  // Result waiting for the output register.
  logic               res_pulse_r, res_pulse_nxt;
  logic [SLEEP_W-1:0] res_sleep_r, res_sleep_nxt;

  // Output register.
  logic               out_valid_r;
  logic               out_pulse_r;
  logic [SLEEP_W-1:0] out_sleep_r;
  logic [FAIL_W-1:0]  out_fail_r;
  logic               out_http_r;

  // Serial units.
  logic                  div_start;
  unit_sts_t             div_sts;
  logic [INTERVAL_W-1:0] div_quo;
  bo_req_t               bo_req;
  unit_sts_t             bo_sts;
  logic [SLEEP_W-1:0]    bo_sleep;

  logic                  in_fire;
  logic                  out_load;
  logic [1:0]            scale;
  logic [SLEEP_W-1:0]    scaled;
  logic [SLEEP_W-1:0]    clamped;
  logic [PULSE_W-1:0]    need;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || out_tready);

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r   <= INTERVAL_W'(300000);
      pulse_r      <= INTERVAL_W'(8000);
      min_r        <= SLEEP_W'(60000);
      max_r        <= SLEEP_W'(3600000);
      batt_low_r   <= MV_W'(3300);
      keep_alive_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_REPORT_INTERVAL: interval_r   <= cfg_wdata[INTERVAL_W-1:0];
        REG_PULSE_PERIOD:    pulse_r      <= cfg_wdata[INTERVAL_W-1:0];
        REG_MIN_SLEEP:       min_r        <= cfg_wdata;
        REG_MAX_SLEEP:       max_r        <= cfg_wdata;
        REG_BATTERY_LOW:     batt_low_r   <= cfg_wdata[MV_W-1:0];
        REG_KEEP_ALIVE:      keep_alive_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Low-battery stretch: a reading at or below the no-reading level is ignored.
  always_comb begin
    scale = SCALE_X1;
    if (batt_r > BATT_NOREAD_MV && batt_r < batt_low_r) begin
      scale = (batt_r < BATT_CRIT_MV) ? SCALE_X4 : SCALE_X2;
    end
    scaled = {{(SLEEP_W-INTERVAL_W){1'b0}}, interval_r} << scale;
    // The floor is checked first, so it wins when the limits are inverted.
    if (scaled < min_r) begin
      clamped = min_r;
    end else if (scaled > max_r) begin
      clamped = max_r;
    end else begin
      clamped = scaled;
    end
  end

  assign need = div_quo[PULSE_W-1:0];

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    failures_nxt  = failures_r;
    pcount_nxt    = pcount_r;
    res_pulse_nxt = res_pulse_r;
    res_sleep_nxt = res_sleep_r;
    div_start     = 1'b0;
    bo_req.start  = 1'b0;
    bo_req.shifts = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        res_pulse_nxt = 1'b0;
        res_sleep_nxt = '0;
        if (op_r == OP_WAKE) begin
          if (!wake_r) begin
            pcount_nxt = '0;
            state_nxt  = S_FIN;
          end else if (keep_alive_r && pulse_r != '0) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          if (ok_r) begin
            failures_nxt = '0;
            pcount_nxt   = '0;
          end else if (failures_r < FAILURE_CAP) begin
            failures_nxt = failures_r + 1'b1;
          end
          if (keep_alive_r) begin
            res_sleep_nxt = {{(SLEEP_W-INTERVAL_W){1'b0}}, pulse_r};
            state_nxt     = S_FIN;
          end else if (failures_nxt == '0) begin
            res_sleep_nxt = clamped;
            state_nxt     = S_FIN;
          end else begin
            bo_req.start  = 1'b1;
            bo_req.shifts = failures_nxt - 1'b1;
            state_nxt     = S_BACK;
          end
        end
      end

      S_DIV: begin
        if (div_sts.done) begin
          // A ratio of one or less means pulses are not worth taking.
          if (need > PULSE_W'(1) && pcount_r < need) begin
            pcount_nxt    = pcount_r + 1'b1;
            res_pulse_nxt = 1'b1;
            res_sleep_nxt = {{(SLEEP_W-INTERVAL_W){1'b0}}, pulse_r};
          end
          state_nxt = S_FIN;
        end
      end

      S_BACK: begin
        if (bo_sts.done) begin
          res_sleep_nxt = bo_sleep;
          state_nxt     = S_FIN;
        end
      end

      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      failures_r  <= '0;
      pcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      failures_r <= failures_nxt;
      pcount_r   <= pcount_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_tuser;
      wake_r <= in_tdata[0];
      ok_r   <= in_tdata[1];
      batt_r <= in_tdata[MV_W+1:2];
    end
    res_pulse_r <= res_pulse_nxt;
    res_sleep_r <= res_sleep_nxt;
    if (out_load) begin
      out_pulse_r <= res_pulse_r;
      out_sleep_r <= res_sleep_r;
      out_fail_r  <= failures_r;
      out_http_r  <= (failures_r >= HTTP_FAIL_MIN);
    end
  end

  wsbs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (interval_r),
    .divisor  (pulse_r),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  wsbs_bo u_bo (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (bo_req),
    .min_sleep (min_r),
    .max_sleep (max_r),
    .sts       (bo_sts),
    .sleep     (bo_sleep)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_pulse_r;
  assign out_tdata  = {3'b000, out_http_r, out_fail_r, out_sleep_r};

endmodule

### rtl/wsbs_div.sv
// ---------------------------------------------------------------------------
// wsbs_div
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ---------------------------------------------------------------------------
module wsbs_div
  import wsbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [INTERVAL_W-1:0] dividend,
  input  logic [INTERVAL_W-1:0] divisor,
  output unit_sts_t             sts,
  output logic [INTERVAL_W-1:0] quotient
);

  localparam int CNT_W = $clog2(INTERVAL_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(INTERVAL_W - 1);

  logic [INTERVAL_W-1:0] rem_r, rem_nxt;
  logic [INTERVAL_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [INTERVAL_W:0]   trial;
  logic                  q_bit;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial   = {rem_r, quo_r[INTERVAL_W-1]};
    q_bit   = (trial >= {1'b0, divisor});
    rem_nxt = q_bit ? INTERVAL_W'(trial - {1'b0, divisor}) : trial[INTERVAL_W-1:0];
    quo_nxt = {quo_r[INTERVAL_W-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

### rtl/wsbs_bo.sv
// ---------------------------------------------------------------------------
// wsbs_bo
// Backoff shifter: doubles the base one bit per cycle, saturating at the cap.
// ---------------------------------------------------------------------------
module wsbs_bo
  import wsbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  bo_req_t            req,
  input  logic [SLEEP_W-1:0] min_sleep,
  input  logic [SLEEP_W-1:0] max_sleep,
  output unit_sts_t          sts,
  output logic [SLEEP_W-1:0] sleep
);

  logic [SLEEP_W-1:0] base_r;
  logic               sat_r;
  logic [FAIL_W-1:0]  cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [SLEEP_W:0]   dbl;
  logic [SLEEP_W-1:0] capped;

  assign dbl = {base_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.shifts;
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Once the running value passes the cap it only grows, so it stays capped.
  always_ff @(posedge clk) begin
    if (req.start) begin
      base_r <= min_sleep;
      sat_r  <= (min_sleep > max_sleep);
    end else if (busy_r && cnt_r != '0 && !sat_r) begin
      base_r <= dbl[SLEEP_W-1:0];
      sat_r  <= dbl[SLEEP_W] || (dbl[SLEEP_W-1:0] > max_sleep);
    end
  end

  // With the cap below the floor, the floor wins.
  assign capped = sat_r ? max_sleep : base_r;
  assign sleep  = (capped < min_sleep) ? min_sleep : capped;

  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

### rtl/wsbs_checker.sv
// ---------------------------------------------------------------------------
// wsbs_checker
// Port-level checks of the wake/sleep backoff scheduler, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wsbs_checker
  import wsbs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  // A stalled result keeps its contents.
  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // One request at a time: the block is busy right after an accepted request.
  `ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "request accepted while busy")

  // The failure count never passes its cap.
  `ASSERT_IMPLY(a_fail_cap, out_tvalid, out_tdata[35:32] <= FAILURE_CAP, "failure count above cap")

  // The fallback flag follows the failure count.
  `ASSERT_IMPLY(a_http_flag, out_tvalid, out_tdata[36] == (out_tdata[35:32] >= HTTP_FAIL_MIN), "fallback flag mismatch")

  // A pulse-only wake always programs a nonzero sleep.
  `ASSERT_IMPLY(a_pulse_sleep, out_tvalid && out_tuser, out_tdata[31:0] != 32'd0, "pulse wake with zero sleep")

endmodule

bind wake_sleep_backoff_scheduler wsbs_checker u_wsbs_checker (.*);
